// ----- rtl/sorted_array_set_engine_unit_macros.svh -----
// assertion macros for the sorted array set engine
`ifndef SORTED_ARRAY_SET_ENGINE_UNIT_MACROS_SVH
`define SORTED_ARRAY_SET_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SASE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SASE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sase_pkg.sv -----
// shared types and constants of the sorted array set engine
`timescale 1ns / 1ps
`default_nettype none

package sase_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int OUT_W    = 24;

  // request kinds
  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // what every cell does at the edge
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } sase_op_t;

  typedef struct packed {
    sase_op_t            op;
    logic [VALUE_W-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sase_cell.sv -----
// one table cell: holds an entry, compares it and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module sase_cell (
  input  wire logic                        clk,
  input  wire sase_pkg::cell_ctrl_t        ctrl,
  input  wire logic                        valid_i,
  input  wire logic                        prev_lt_i,
  input  wire logic [sase_pkg::VALUE_W-1:0] left_i,
  input  wire logic [sase_pkg::VALUE_W-1:0] right_i,
  output logic                             lt_o,
  output logic                             bnd_o,
  output logic                             hit_o,
  output logic [sase_pkg::VALUE_W-1:0]     entry_o
);

  logic [sase_pkg::VALUE_W-1:0] entry_r;
  logic [sase_pkg::VALUE_W-1:0] entry_nxt;
  logic                         at_pos;

  assign lt_o    = valid_i && ($signed(entry_r) < $signed(ctrl.value));
  // first cell not below the value; also the free slot when all are below
  assign at_pos  = !lt_o && prev_lt_i;
  assign bnd_o   = valid_i && at_pos;
  assign hit_o   = bnd_o && (entry_r == ctrl.value);
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.op)
      sase_pkg::OP_INSERT: begin
        if (!lt_o) begin
          entry_nxt = at_pos ? ctrl.value : left_i;
        end
      end
      sase_pkg::OP_REMOVE: begin
        if (!lt_o) begin
          entry_nxt = right_i;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/sase_encode.sv -----
// one-hot to binary encoder for the cell row boundary
`timescale 1ns / 1ps
`default_nettype none

module sase_encode #(
  parameter int DEPTH = sase_pkg::DEPTH_DEFAULT
) (
  input  wire logic [DEPTH-1:0]         onehot_i,
  output logic [$clog2(DEPTH)-1:0]      idx_o,
  output logic                          any_o
);

  localparam int IW = $clog2(DEPTH);

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (onehot_i[i]) begin
        idx_o = idx_o | IW'(i);
      end
    end
  end

  assign any_o = |onehot_i;

endmodule

`default_nettype wire

// ----- rtl/sorted_array_set_engine_unit.sv -----
// top level of the sorted array set engine: request stage, cell row, result register
// Keeps up to DEPTH signed 32-bit values in ascending order (duplicates kept) in a
// row of DEPTH cells, one entry per cell. A request names insert, remove or contains
// and carries one value. Every cell compares its entry with the value at once; the
// boundary between "below" and "not below" cells gives the lower bound position. On
// insert the boundary cell takes the value and every cell above it takes its left
// neighbor's entry; on remove every cell at or above it takes its right neighbor's
// entry, all in the same edge. A request is registered on acceptance, does its
// compare and shift once the result register is free or draining, and then writes
// its result there; one request per cycle is taken while the result channel does not
// stall, set by the compare-and-shift across the cell row. A waiting result stalls a
// full request stage. An insert into a full table reports full and changes nothing;
// position and count are reported modulo 128. Of the table, only the fill count is
// reset; cell contents beyond it are never looked at, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_array_set_engine_unit_macros.svh"

module sorted_array_set_engine_unit #(
  parameter int DEPTH = sase_pkg::DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [sase_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  wire logic [sase_pkg::CMD_W-1:0]   in_tuser,   // [1:0] cmd
  // result channel
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [1:0] status, [2] found, [9:3] position, [16:10] count, [23:17] zero
  output logic [sase_pkg::OUT_W-1:0]        out_tdata
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  // request stage
  logic                           req_valid_r;
  logic [sase_pkg::CMD_W-1:0]     req_cmd_r;
  logic [sase_pkg::VALUE_W-1:0]   req_value_r;

  // table fill
  logic [FW-1:0]                  fill_r;
  logic [FW-1:0]                  fill_nxt;

  // result register
  logic                           out_valid_r;
  logic [sase_pkg::STATUS_W-1:0]  out_status_r;
  logic                           out_found_r;
  logic [sase_pkg::POS_W-1:0]     out_pos_r;
  logic [sase_pkg::POS_W-1:0]     out_count_r;

  // cell row wiring
  logic [DEPTH-1:0]               cell_lt;
  logic [DEPTH-1:0]               cell_bnd;
  logic [DEPTH-1:0]               cell_hit;
  logic [sase_pkg::VALUE_W-1:0]   cell_entry [DEPTH];
  sase_pkg::cell_ctrl_t           ctrl;

  logic                           fire;
  logic                           full;
  logic                           hit;
  logic                           bnd_any;
  logic [IW-1:0]                  bnd_idx;
  logic [FW-1:0]                  pos;
  logic [sase_pkg::STATUS_W-1:0]  status;

  // work happens when a request waits and the result slot is free or draining
  assign fire      = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !req_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_tready) begin
      req_valid_r <= in_tvalid;
    end
  end

  // request payload, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_cmd_r   <= in_tuser;
      req_value_r <= in_tdata;
    end
  end

  // cell row: cell 0 sees a "below" neighbor, the last cell repeats itself on remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         valid;
    logic                         prev_lt;
    logic [sase_pkg::VALUE_W-1:0] left;
    logic [sase_pkg::VALUE_W-1:0] right;

    assign valid = FW'(i) < fill_r;

    if (i == 0) begin : g_first
      assign prev_lt = 1'b1;
      assign left    = req_value_r;
    end else begin : g_mid
      assign prev_lt = cell_lt[i-1];
      assign left    = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = cell_entry[i];
    end else begin : g_body
      assign right = cell_entry[i+1];
    end

    sase_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid_i   (valid),
      .prev_lt_i (prev_lt),
      .left_i    (left),
      .right_i   (right),
      .lt_o      (cell_lt[i]),
      .bnd_o     (cell_bnd[i]),
      .hit_o     (cell_hit[i]),
      .entry_o   (cell_entry[i])
    );
  end

  sase_encode #(
    .DEPTH (DEPTH)
  ) u_encode (
    .onehot_i (cell_bnd),
    .idx_o    (bnd_idx),
    .any_o    (bnd_any)
  );

  // no boundary among stored cells means every stored value is below
  assign pos  = bnd_any ? FW'(bnd_idx) : fill_r;
  assign hit  = |cell_hit;
  assign full = (fill_r == FW'(DEPTH));

  // decode the request into a row operation and a result code
  always_comb begin
    ctrl.op    = sase_pkg::OP_HOLD;
    ctrl.value = req_value_r;
    fill_nxt   = fill_r;
    status     = hit ? sase_pkg::ST_DONE : sase_pkg::ST_ABSENT;
    unique case (req_cmd_r)
      sase_pkg::CMD_INSERT: begin
        if (full) begin
          status = sase_pkg::ST_FULL;
        end else begin
          status = sase_pkg::ST_DONE;
          if (fire) begin
            ctrl.op  = sase_pkg::OP_INSERT;
            fill_nxt = fill_r + FW'(1);
          end
        end
      end
      sase_pkg::CMD_REMOVE: begin
        if (hit && fire) begin
          ctrl.op  = sase_pkg::OP_REMOVE;
          fill_nxt = fill_r - FW'(1);
        end
      end
      // contains and the unused code only look
      default: ctrl.op = sase_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status;
      out_found_r  <= hit;
      out_pos_r    <= sase_pkg::POS_W'(pos);
      out_count_r  <= sase_pkg::POS_W'(fill_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_count_r, out_pos_r, out_found_r, out_status_r};

  // checks
  `SASE_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FW'(DEPTH), "fill beyond depth")
  `SASE_ASSERT_NOW(a_bnd_onehot, req_valid_r, $onehot0(cell_bnd), "more than one boundary cell")
  `SASE_ASSERT_NEXT(a_insert_grows, fire && (ctrl.op == sase_pkg::OP_INSERT),
    fill_r == $past(fill_r) + FW'(1), "insert did not grow the table")
  `SASE_ASSERT_NOW(a_full_count, out_valid_r && (out_status_r == sase_pkg::ST_FULL),
    out_count_r == sase_pkg::POS_W'(DEPTH), "full status with table not full")
  `SASE_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_tready,
    out_valid_r && $stable(out_tdata), "result dropped while stalled")

endmodule

`default_nettype wire
